FILE: rtl/serial_register_access_master_macros.svh
// Assertion macros shared by the serial register access master RTL.
`ifndef SERIAL_REGISTER_ACCESS_MASTER_MACROS_SVH
`define SERIAL_REGISTER_ACCESS_MASTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sra assertion failed: same-cycle check");

// Consequent must hold in the cycle after the antecedent.
`define SRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sra assertion failed: next-cycle check");

`endif

FILE: rtl/sra_pkg.sv
// Package with the phase script table and codes of the serial register access master.
package sra_pkg;

  // Input selector codes.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Data line action taken when a phase is entered.
  localparam logic [2:0] DAT_KEEP    = 3'd0;
  localparam logic [2:0] DAT_RELEASE = 3'd1;
  localparam logic [2:0] DAT_LOW     = 3'd2;
  localparam logic [2:0] DAT_HIGH    = 3'd3;
  localparam logic [2:0] DAT_MSB     = 3'd4;

  // Shift register load source on phase entry.
  localparam logic [2:0] LD_NONE   = 3'd0;
  localparam logic [2:0] LD_DEV_WR = 3'd1;
  localparam logic [2:0] LD_ADDR   = 3'd2;
  localparam logic [2:0] LD_DATA   = 3'd3;
  localparam logic [2:0] LD_DEV_RD = 3'd4;

  // Action taken when a phase ends.
  localparam logic [2:0] END_NEXT   = 3'd0;
  localparam logic [2:0] END_INBIT  = 3'd2;
  localparam logic [2:0] END_OUTBIT = 3'd3;
  localparam logic [2:0] END_FINISH = 3'd4;

  // Register indexes on the configuration port.
  localparam logic CFG_DEV_ADDR    = 1'b0;
  localparam logic CFG_PHASE_TICKS = 1'b1;

  localparam int unsigned SCRIPT_LEN = 56;
  localparam logic [5:0]  STEP_LAST  = 6'd56;
  localparam logic [5:0]  WRITE_ENTRY = 6'd1;
  localparam logic [5:0]  READ_ENTRY = 6'd23;

  localparam logic [6:0]  DEV_ADDR_RESET    = 7'd110;
  localparam logic [15:0] PHASE_TICKS_RESET = 16'd2000;

  typedef struct packed {
    logic       scl;
    logic [2:0] dat;
    logic [2:0] load;
    logic [2:0] endop;
  } phase_t;

  localparam phase_t SCRIPT [SCRIPT_LEN] = '{
    // Write script.
    '{1'b1, DAT_KEEP, LD_NONE, END_NEXT}, '{1'b1, DAT_HIGH, LD_NONE, END_NEXT},
    '{1'b1, DAT_LOW, LD_NONE, END_NEXT},
    '{1'b0, DAT_KEEP, LD_DEV_WR, END_NEXT}, '{1'b0, DAT_MSB, LD_NONE, END_NEXT},
    '{1'b1, DAT_KEEP, LD_NONE, END_OUTBIT},
    '{1'b0, DAT_KEEP, LD_NONE, END_NEXT}, '{1'b1, DAT_RELEASE, LD_NONE, END_NEXT},
    '{1'b0, DAT_KEEP, LD_ADDR, END_NEXT}, '{1'b0, DAT_MSB, LD_NONE, END_NEXT},
    '{1'b1, DAT_KEEP, LD_NONE, END_OUTBIT},
    '{1'b0, DAT_KEEP, LD_NONE, END_NEXT}, '{1'b1, DAT_RELEASE, LD_NONE, END_NEXT},
    '{1'b0, DAT_KEEP, LD_DATA, END_NEXT}, '{1'b0, DAT_MSB, LD_NONE, END_NEXT},
    '{1'b1, DAT_KEEP, LD_NONE, END_OUTBIT},
    '{1'b0, DAT_KEEP, LD_NONE, END_NEXT}, '{1'b1, DAT_RELEASE, LD_NONE, END_NEXT},
    '{1'b0, DAT_KEEP, LD_NONE, END_NEXT}, '{1'b0, DAT_LOW, LD_NONE, END_NEXT},
    '{1'b1, DAT_KEEP, LD_NONE, END_NEXT}, '{1'b1, DAT_HIGH, LD_NONE, END_FINISH},
    // Read script.
    '{1'b1, DAT_KEEP, LD_NONE, END_NEXT}, '{1'b1, DAT_HIGH, LD_NONE, END_NEXT},
    '{1'b1, DAT_LOW, LD_NONE, END_NEXT},
    '{1'b0, DAT_KEEP, LD_DEV_WR, END_NEXT}, '{1'b0, DAT_MSB, LD_NONE, END_NEXT},
    '{1'b1, DAT_KEEP, LD_NONE, END_OUTBIT},
    '{1'b0, DAT_KEEP, LD_NONE, END_NEXT}, '{1'b1, DAT_RELEASE, LD_NONE, END_NEXT},
    '{1'b0, DAT_KEEP, LD_ADDR, END_NEXT}, '{1'b0, DAT_MSB, LD_NONE, END_NEXT},
    '{1'b1, DAT_KEEP, LD_NONE, END_OUTBIT},
    '{1'b0, DAT_KEEP, LD_NONE, END_NEXT}, '{1'b1, DAT_RELEASE, LD_NONE, END_NEXT},
    '{1'b0, DAT_KEEP, LD_NONE, END_NEXT}, '{1'b0, DAT_LOW, LD_NONE, END_NEXT},
    '{1'b1, DAT_KEEP, LD_NONE, END_NEXT}, '{1'b1, DAT_HIGH, LD_NONE, END_NEXT},
    '{1'b1, DAT_KEEP, LD_NONE, END_NEXT}, '{1'b1, DAT_HIGH, LD_NONE, END_NEXT},
    '{1'b1, DAT_LOW, LD_NONE, END_NEXT},
    '{1'b0, DAT_KEEP, LD_DEV_RD, END_NEXT}, '{1'b0, DAT_MSB, LD_NONE, END_NEXT},
    '{1'b1, DAT_KEEP, LD_NONE, END_OUTBIT},
    '{1'b0, DAT_KEEP, LD_NONE, END_NEXT}, '{1'b1, DAT_RELEASE, LD_NONE, END_NEXT},
    '{1'b0, DAT_KEEP, LD_NONE, END_NEXT}, '{1'b1, DAT_RELEASE, LD_NONE, END_INBIT},
    '{1'b0, DAT_KEEP, LD_NONE, END_NEXT}, '{1'b0, DAT_HIGH, LD_NONE, END_NEXT},
    '{1'b1, DAT_KEEP, LD_NONE, END_NEXT},
    '{1'b0, DAT_KEEP, LD_NONE, END_NEXT}, '{1'b0, DAT_LOW, LD_NONE, END_NEXT},
    '{1'b1, DAT_KEEP, LD_NONE, END_NEXT}, '{1'b1, DAT_HIGH, LD_NONE, END_FINISH}
  };

endpackage

FILE: rtl/serial_register_access_master.sv
// Top level of the serial register access master: phase sequencer and stream ports.

// This block runs register write and read transactions on a two-wire (I2C or SCCB
// style) bus. Each input beat is either a time tick or a start command; a start
// command that arrives while idle latches the register address (and the data byte
// for a write) and enters the first line phase, and every phase_ticks ticks the
// sequencer steps to the next phase of a fixed script. Commands that arrive while a
// transaction runs are dropped and do not count as ticks. Every accepted input beat
// yields exactly one result beat carrying the driven clock level, the data line
// drive enable and level, busy, a done pulse on the tick the final stop phase ends,
// and the byte from the last completed read. Acknowledge bits are neither sampled
// nor checked. The block takes one beat per clock cycle: the sequencer update is a
// single pass of logic from the state registers to the result register, and one
// output register decouples the two sides, so in_tready is only low while a
// finished result waits in that register and out_tready is low. The result beat of
// an accepted input beat appears in the cycle after it. Configuration writes are
// expected only while the block is idle.

`include "serial_register_access_master_macros.svh"

module serial_register_access_master
  import sra_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // reg_addr[7:0], write_data[15:8], sda_in[16], zero pad
  input  logic [1:0]  in_tuser,   // func[1:0]
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  // scl[0], sda_drive[1], sda_level[2], busy_res[3], done_res[4], read_data[12:5], pad
  output logic [15:0] out_tdata,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  // Configuration registers.
  logic [6:0]  dev_addr_r;
  logic [15:0] phase_ticks_r;

  // Sequencer state.
  logic [5:0]  step_r,  step_nxt;
  logic [15:0] tick_r,  tick_nxt;
  logic [2:0]  bit_r,   bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  rdbyte_r, rdbyte_nxt;
  logic [7:0]  addr_r,  addr_nxt;
  logic [7:0]  data_r,  data_nxt;
  logic        scl_r,   scl_nxt;
  logic        drv_r,   drv_nxt;
  logic        lvl_r,   lvl_nxt;
  logic        done_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_data_r,  out_data_nxt;

  logic [1:0]  func;
  logic [7:0]  in_reg_addr;
  logic [7:0]  in_write_data;
  logic        in_sda;
  logic        in_accept;
  logic        busy;
  logic [15:0] limit;
  logic        phase_end;
  phase_t      cur_ph;
  phase_t      new_ph;
  logic        enter;
  logic [5:0]  next_step;

  assign func          = in_tuser;
  assign in_reg_addr   = in_tdata[7:0];
  assign in_write_data = in_tdata[15:8];
  assign in_sda        = in_tdata[16];

  // A result waiting in the output register only blocks input while it is stalled.
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  assign busy      = (step_r != 6'd0);
  // A phase length of zero behaves like one.
  assign limit     = (phase_ticks_r == 16'd0) ? 16'd1 : phase_ticks_r;
  assign phase_end = ({1'b0, tick_r} + 17'd1) >= {1'b0, limit};
  assign cur_ph    = SCRIPT[step_r - 6'd1];

  always_comb begin
    step_nxt   = step_r;
    tick_nxt   = tick_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    rdbyte_nxt = rdbyte_r;
    addr_nxt   = addr_r;
    data_nxt   = data_r;
    scl_nxt    = scl_r;
    drv_nxt    = drv_r;
    lvl_nxt    = lvl_r;
    done_nxt   = 1'b0;
    enter      = 1'b0;
    next_step  = step_r + 6'd1;
    new_ph     = '0;

    if (!busy && (func == FUNC_WRITE || func == FUNC_READ)) begin
      addr_nxt = in_reg_addr;
      if (func == FUNC_WRITE) begin
        data_nxt = in_write_data;
      end
      bit_nxt  = 3'd0;
      tick_nxt = 16'd0;
      step_nxt = (func == FUNC_WRITE) ? WRITE_ENTRY : READ_ENTRY;
      enter    = 1'b1;
    end else if (busy && func == FUNC_TICK) begin
      if (phase_end) begin
        tick_nxt = 16'd0;
        if (cur_ph.endop == END_OUTBIT) begin
          shift_nxt = {shift_r[6:0], 1'b0};
          bit_nxt   = bit_r + 3'd1;
          if (bit_nxt != 3'd0) begin
            next_step = step_r - 6'd2;
          end
        end else if (cur_ph.endop == END_INBIT) begin
          shift_nxt = {shift_r[6:0], in_sda};
          bit_nxt   = bit_r + 3'd1;
          if (bit_nxt != 3'd0) begin
            next_step = step_r - 6'd1;
          end else begin
            rdbyte_nxt = shift_nxt;
          end
        end
        if (cur_ph.endop == END_FINISH || next_step > STEP_LAST || next_step == 6'd0) begin
          step_nxt = 6'd0;
          done_nxt = 1'b1;
        end else begin
          step_nxt = next_step;
          enter    = 1'b1;
        end
      end else begin
        tick_nxt = tick_r + 16'd1;
      end
    end

    // Phase entry: optional byte load at the start of a byte, then set the lines.
    if (enter) begin
      new_ph = SCRIPT[step_nxt - 6'd1];
      if (bit_nxt == 3'd0) begin
        unique case (new_ph.load)
          LD_NONE:   shift_nxt = shift_nxt;
          LD_DEV_WR: shift_nxt = {dev_addr_r, 1'b0};
          LD_ADDR:   shift_nxt = addr_nxt;
          LD_DATA:   shift_nxt = data_nxt;
          LD_DEV_RD: shift_nxt = {dev_addr_r, 1'b1};
          default:   shift_nxt = shift_nxt;
        endcase
      end
      scl_nxt = new_ph.scl;
      unique case (new_ph.dat)
        DAT_KEEP:    ;
        DAT_RELEASE: drv_nxt = 1'b0;
        DAT_LOW: begin
          drv_nxt = 1'b1;
          lvl_nxt = 1'b0;
        end
        DAT_HIGH: begin
          drv_nxt = 1'b1;
          lvl_nxt = 1'b1;
        end
        DAT_MSB: begin
          drv_nxt = 1'b1;
          lvl_nxt = shift_nxt[7];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_data_nxt = {3'd0, rdbyte_nxt, done_nxt, (step_nxt != 6'd0), lvl_nxt, drv_nxt,
                    scl_nxt};
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r    <= DEV_ADDR_RESET;
      phase_ticks_r <= PHASE_TICKS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DEV_ADDR) begin
        dev_addr_r <= cfg_wdata[6:0];
      end else begin
        phase_ticks_r <= cfg_wdata;
      end
    end
  end

  // Sequencer state advances only on accepted beats.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= 6'd0;
      tick_r   <= 16'd0;
      bit_r    <= 3'd0;
      shift_r  <= 8'd0;
      rdbyte_r <= 8'd0;
      addr_r   <= 8'd0;
      data_r   <= 8'd0;
      scl_r    <= 1'b1;
      drv_r    <= 1'b0;
      lvl_r    <= 1'b1;
    end else if (in_accept) begin
      step_r   <= step_nxt;
      tick_r   <= tick_nxt;
      bit_r    <= bit_nxt;
      shift_r  <= shift_nxt;
      rdbyte_r <= rdbyte_nxt;
      addr_r   <= addr_nxt;
      data_r   <= data_nxt;
      scl_r    <= scl_nxt;
      drv_r    <= drv_nxt;
      lvl_r    <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The sequencer never runs past the last phase of the script.
  `SRA_ASSERT_NOW(a_step_range, 1'b1, step_r <= STEP_LAST)
  // A done pulse always reports the bus as no longer busy.
  `SRA_ASSERT_NOW(a_done_not_busy, out_valid_r && out_data_r[4], !out_data_r[3])
  // Every accepted beat produces a result beat in the following cycle.
  `SRA_ASSERT_NEXT(a_accept_result, in_accept, out_valid_r)
  // A done pulse is only produced from a running transaction.
  `SRA_ASSERT_NEXT(a_done_from_busy, in_accept && !busy, !out_data_r[4])

endmodule
